// ----- rtl/scalc_pkg.sv -----
// scalc_pkg: shared constants, command and status codes, and fixed-point helpers
// for the stack calculator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scalc_pkg;

   // sizes
   localparam int STACK_DEPTH  = 5;
   localparam int FRAC_BITS    = 16;
   localparam int MAX_EXPONENT = 63;
   localparam int DEPTH_W      = 3;
   localparam int EXP_W        = $clog2(MAX_EXPONENT + 1);
   localparam int DVD_W        = 32 + FRAC_BITS;
   localparam int DIV_CNT_W    = $clog2(DVD_W + 1);

   localparam logic [31:0] FRAC_MASK = (32'h1 << FRAC_BITS) - 32'h1;
   localparam logic signed [31:0] FX_ONE = 32'sh1 <<< FRAC_BITS;

   // command codes
   localparam logic [3:0] OP_PUSH    = 4'd0;
   localparam logic [3:0] OP_DROP    = 4'd1;
   localparam logic [3:0] OP_CLEAR   = 4'd2;
   localparam logic [3:0] OP_ADD     = 4'd3;
   localparam logic [3:0] OP_SUB     = 4'd4;
   localparam logic [3:0] OP_MUL     = 4'd5;
   localparam logic [3:0] OP_DIV     = 4'd6;
   localparam logic [3:0] OP_POW     = 4'd7;
   localparam logic [3:0] OP_MOD     = 4'd8;
   localparam logic [3:0] OP_MAX     = 4'd9;
   localparam logic [3:0] OP_MIN     = 4'd10;
   localparam logic [3:0] OP_AVG     = 4'd11;
   localparam logic [3:0] OP_ABSDIFF = 4'd12;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_DIVZERO   = 2'd2;
   localparam logic [1:0] ST_INVALID   = 2'd3;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // integer part, truncated toward zero
   function automatic logic signed [31:0] fx_trunc(input logic signed [31:0] x);
      logic signed [31:0] q;
      q = x >>> FRAC_BITS;
      if (x[31] && ((x & FRAC_MASK) != 32'h0)) begin
         q = q + 32'sd1;
      end
      return q;
   endfunction

   // magnitude as unsigned
   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      logic [31:0] m;
      m = x[31] ? 32'(-x) : 32'(x);
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/scalc_mul.sv -----
// scalc_mul: shared fixed-point multiplier, product registered, then floor shift
// and saturation. Depends on scalc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scalc_mul
   import scalc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic signed [31:0] mul_x,
   input  wire logic signed [31:0] mul_y,
   output logic signed [31:0]      mul_result
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   // full 64-bit product, combinational
   assign prod_in = 64'(mul_x) * 64'(mul_y);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // arithmetic shift floors, then clamp
   assign mul_result = sat32(prod_ff >>> FRAC_BITS);

endmodule

`default_nettype wire

// ----- rtl/scalc_div.sv -----
// scalc_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on scalc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scalc_div
   import scalc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             div_start,
   input  wire logic [DVD_W-1:0] div_dividend,
   input  wire logic [31:0]      div_divisor,
   output logic                  div_done,
   output logic [DVD_W-1:0]      div_quotient,
   output logic [31:0]           div_remainder
);

   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [32:0]          rem_sh;
   logic [32:0]          trial;

   // shift in next dividend bit and try subtracting
   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial  = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_start) begin
         dvd_in  = div_dividend;
         rem_in  = 32'h0;
         dvs_in  = div_divisor;
         cnt_in  = DIV_CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_done      = done_ff;
   assign div_quotient  = dvd_ff;
   assign div_remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/stack_calculator_alu.sv -----
// stack_calculator_alu: reverse-Polish operand stack of signed Q16.16 values.
// Instantiates scalc_mul and scalc_div; depends on scalc_pkg.
//
// Usage:
//  - req channel: one command word (req_opcode, req_operand_value) per handshake.
//    req_ready is high only while the sequencer is idle; one command at a time.
//  - rsp channel: one result word per command (rsp_status, rsp_stack_depth,
//    rsp_top_value), held in an output register until rsp_ready.
//  - path: push, drop, clear, add, sub, max, min, avg, absdiff and every error
//    status go from S_EXEC straight to S_OUT; mul passes through S_MUL for the
//    registered multiplier; div and mod wait in S_DIV on the divider, which
//    yields one quotient bit per cycle; pow runs S_POW_MUL then S_POW_ACC once
//    per unit of exponent n (clamped to 0..63) through the shared multiplier.
//  - the next command is taken once the sequencer is back in idle, while the
//    previous result may still sit in the output register.
//  - a stalled receiver holds a finished result in the sequencer until the
//    output register frees; nothing is dropped.
//  - reset (synchronous, active high) empties the stack, zeroes the entries
//    and clears rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module stack_calculator_alu
   import scalc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [3:0]         req_opcode,
   input  wire logic signed [31:0] req_operand_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [DEPTH_W-1:0]      rsp_stack_depth,
   output logic signed [31:0]      rsp_top_value
);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EXEC    = 3'd1;
   localparam logic [2:0] S_MUL     = 3'd2;
   localparam logic [2:0] S_POW_MUL = 3'd3;
   localparam logic [2:0] S_POW_ACC = 3'd4;
   localparam logic [2:0] S_DIV     = 3'd5;
   localparam logic [2:0] S_OUT     = 3'd6;

   // stack update commands
   localparam logic [2:0] SK_NONE   = 3'd0;
   localparam logic [2:0] SK_PUSH   = 3'd1;
   localparam logic [2:0] SK_DROP   = 3'd2;
   localparam logic [2:0] SK_REDUCE = 3'd3;
   localparam logic [2:0] SK_CLEAR  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [3:0]               op_ff, op_in;
   logic signed [31:0]       val_ff, val_in;
   logic signed [31:0]       entry_ff [STACK_DEPTH];
   logic signed [31:0]       entry_in [STACK_DEPTH];
   logic [DEPTH_W-1:0]       count_ff, count_in;
   logic [1:0]               status_ff, status_in;
   logic signed [31:0]       acc_ff, acc_in;
   logic [EXP_W-1:0]         exp_ff, exp_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [DEPTH_W-1:0]       rsp_depth_ff, rsp_depth_in;
   logic signed [31:0]       rsp_top_ff, rsp_top_in;

   logic [2:0]               stk_cmd;
   logic signed [31:0]       stk_result;
   logic signed [31:0]       op_a, op_b;
   logic signed [63:0]       sum64, diff64, absd64;
   logic signed [31:0]       ia, ib;
   logic [EXP_W-1:0]         exp_n;
   logic signed [31:0]       mul_x, mul_result;
   logic                     div_start, div_done;
   logic [DVD_W-1:0]         div_dividend, div_quotient;
   logic [31:0]              div_divisor, div_remainder;
   logic signed [63:0]       quo64, rem64;

   // a is the second entry, b the top
   assign op_a = entry_ff[1];
   assign op_b = entry_ff[0];

   assign sum64  = 64'(op_a) + 64'(op_b);
   assign diff64 = 64'(op_a) - 64'(op_b);
   assign absd64 = diff64[63] ? -diff64 : diff64;

   assign ia = fx_trunc(op_a);
   assign ib = fx_trunc(op_b);

   // exponent clamp
   always_comb begin
      if (ib[31]) begin
         exp_n = '0;
      end else if (ib > 32'(MAX_EXPONENT)) begin
         exp_n = EXP_W'(MAX_EXPONENT);
      end else begin
         exp_n = ib[EXP_W-1:0];
      end
   end

   // shared multiplier: pow folds the accumulator with a
   assign mul_x = (op_ff == OP_POW) ? acc_ff : op_b;

   scalc_mul u_mul (
      .clock      (clock),
      .mul_x      (mul_x),
      .mul_y      (op_a),
      .mul_result (mul_result)
   );

   // shared divider: div takes |a|*ONE / |b|, mod takes |ia| % |ib|
   assign div_dividend = (op_ff == OP_DIV) ? (DVD_W'(mag32(op_a)) << FRAC_BITS)
                                           : DVD_W'(mag32(ia));
   assign div_divisor  = (op_ff == OP_DIV) ? mag32(op_b) : mag32(ib);

   scalc_div u_div (
      .clock         (clock),
      .reset         (reset),
      .div_start     (div_start),
      .div_dividend  (div_dividend),
      .div_divisor   (div_divisor),
      .div_done      (div_done),
      .div_quotient  (div_quotient),
      .div_remainder (div_remainder)
   );

   assign quo64 = neg_ff ? -64'(div_quotient) : 64'(div_quotient);
   assign rem64 = neg_ff ? -64'(div_remainder) : 64'(div_remainder);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      acc_in        = acc_ff;
      exp_in        = exp_ff;
      neg_in        = neg_ff;
      stk_cmd       = SK_NONE;
      stk_result    = mul_result;
      div_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_top_in    = rsp_top_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               val_in   = req_operand_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            state_in  = S_OUT;
            case (op_ff)
               OP_PUSH: begin
                  stk_cmd = SK_PUSH;
               end
               OP_DROP: begin
                  if (count_ff == '0) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     stk_cmd = SK_DROP;
                  end
               end
               OP_CLEAR: begin
                  stk_cmd = SK_CLEAR;
               end
               default: begin
                  if (op_ff > OP_ABSDIFF) begin
                     status_in = ST_INVALID;
                  end else if (count_ff < DEPTH_W'(2)) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     case (op_ff)
                        OP_ADD: begin
                           stk_cmd    = SK_REDUCE;
                           stk_result = sat32(sum64);
                        end
                        OP_SUB: begin
                           stk_cmd    = SK_REDUCE;
                           stk_result = sat32(diff64);
                        end
                        OP_MUL: begin
                           state_in = S_MUL;
                        end
                        OP_DIV: begin
                           if (op_b == 32'sd0) begin
                              status_in = ST_DIVZERO;
                           end else begin
                              div_start = 1'b1;
                              neg_in    = op_a[31] ^ op_b[31];
                              state_in  = S_DIV;
                           end
                        end
                        OP_POW: begin
                           acc_in = FX_ONE;
                           exp_in = exp_n;
                           if (exp_n == '0) begin
                              stk_cmd    = SK_REDUCE;
                              stk_result = FX_ONE;
                           end else begin
                              state_in = S_POW_MUL;
                           end
                        end
                        OP_MOD: begin
                           if (ib == 32'sd0) begin
                              status_in = ST_DIVZERO;
                           end else begin
                              div_start = 1'b1;
                              neg_in    = ia[31];
                              state_in  = S_DIV;
                           end
                        end
                        OP_MAX: begin
                           stk_cmd    = SK_REDUCE;
                           stk_result = (op_a > op_b) ? op_a : op_b;
                        end
                        OP_MIN: begin
                           stk_cmd    = SK_REDUCE;
                           stk_result = (op_a < op_b) ? op_a : op_b;
                        end
                        OP_AVG: begin
                           stk_cmd    = SK_REDUCE;
                           stk_result = sum64[32:1];
                        end
                        default: begin
                           stk_cmd    = SK_REDUCE;
                           stk_result = sat32(absd64);
                        end
                     endcase
                  end
               end
            endcase
         end
         S_MUL: begin
            stk_cmd  = SK_REDUCE;
            state_in = S_OUT;
         end
         S_POW_MUL: begin
            state_in = S_POW_ACC;
         end
         S_POW_ACC: begin
            if (exp_ff == EXP_W'(1)) begin
               stk_cmd  = SK_REDUCE;
               state_in = S_OUT;
            end else begin
               acc_in   = mul_result;
               exp_in   = exp_ff - EXP_W'(1);
               state_in = S_POW_MUL;
            end
         end
         S_DIV: begin
            if (div_done) begin
               stk_cmd  = SK_REDUCE;
               state_in = S_OUT;
               if (op_ff == OP_DIV) begin
                  stk_result = sat32(quo64);
               end else begin
                  stk_result = sat32(rem64 <<< FRAC_BITS);
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_depth_in  = count_ff;
               rsp_top_in    = (count_ff == '0) ? 32'sd0 : entry_ff[0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // stack with the top at entry 0
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
      end
      case (stk_cmd)
         SK_PUSH: begin
            entry_in[0] = val_ff;
            for (int i = 1; i < STACK_DEPTH; i++) begin
               entry_in[i] = entry_ff[i-1];
            end
            if (count_ff != DEPTH_W'(STACK_DEPTH)) begin
               count_in = count_ff + DEPTH_W'(1);
            end
         end
         SK_DROP: begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
               entry_in[i] = entry_ff[i+1];
            end
            count_in = count_ff - DEPTH_W'(1);
         end
         SK_REDUCE: begin
            entry_in[0] = stk_result;
            for (int i = 1; i < STACK_DEPTH - 1; i++) begin
               entry_in[i] = entry_ff[i+1];
            end
            count_in = count_ff - DEPTH_W'(1);
         end
         SK_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STACK_DEPTH; i++) begin
            entry_ff[i] <= 32'sd0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < STACK_DEPTH; i++) begin
            entry_ff[i] <= entry_in[i];
         end
      end
      op_ff         <= op_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      acc_ff        <= acc_in;
      exp_ff        <= exp_in;
      neg_ff        <= neg_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_top_ff    <= rsp_top_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_stack_depth = rsp_depth_ff;
   assign rsp_top_value   = rsp_top_ff;

   // depth never exceeds the stack size
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_W'(STACK_DEPTH))
      else $error("stack count out of range");

   // empty stack reports a zero top
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_depth_ff == '0) |-> rsp_top_ff == 32'sd0)
      else $error("nonzero top on empty stack");

   // an accepted word always starts decode next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_EXEC)
      else $error("accepted word not decoded");

   // error statuses never change the depth
   a_err_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) && (status_in != ST_OK) |=> $stable(count_ff))
      else $error("stack changed on error");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for stack_calculator_alu (operand stack calculator).
// Depends on scalc_pkg and the stack_calculator_alu rtl; checks every result word.
`timescale 1ns / 1ps

module testbench;
   import scalc_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [3:0]         req_opcode;
   logic signed [31:0] req_operand_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic [DEPTH_W-1:0] rsp_stack_depth;
   logic signed [31:0] rsp_top_value;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] value;
   } cmd_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [2:0]         depth;
      logic signed [31:0] top;
   } result_word_type;

   cmd_word_type    pending_cmds[$];
   result_word_type expected_results[$];

   // predictor copy of the stack
   logic signed [31:0] calc_stack[STACK_DEPTH];
   int unsigned        calc_count;

   int  error_count;
   int  idle_cycles;
   int  burst_left;
   int  gap_left;
   int  stall_phase;
   bit  stim_done;

   localparam int WATCHDOG_LIMIT = 20000;

   stack_calculator_alu dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_operand_value(req_operand_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_stack_depth(rsp_stack_depth),
      .rsp_top_value(rsp_top_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // arithmetic shift floors toward minus infinity
   function automatic logic signed [63:0] fixed_mul(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b;
      return clamp32(p >>> FRAC_BITS);
   endfunction

   // update the stack copy and return the result word of one command
   function automatic result_word_type calc_command(input cmd_word_type c);
      result_word_type    r;
      logic signed [63:0] a, b, v, n, ia, ib;
      logic [1:0]         st;
      st = ST_OK;
      v  = 0;
      if (c.opcode > OP_ABSDIFF) begin
         st = ST_INVALID;
      end else if (c.opcode == OP_PUSH) begin
         if (calc_count >= STACK_DEPTH) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) calc_stack[i] = calc_stack[i + 1];
            calc_stack[STACK_DEPTH - 1] = c.value;
         end else begin
            calc_stack[calc_count] = c.value;
            calc_count++;
         end
      end else if (c.opcode == OP_DROP) begin
         if (calc_count == 0) st = ST_UNDERFLOW;
         else calc_count--;
      end else if (c.opcode == OP_CLEAR) begin
         calc_count = 0;
      end else if (calc_count < 2) begin
         st = ST_UNDERFLOW;
      end else begin
         b = calc_stack[calc_count - 1];
         a = calc_stack[calc_count - 2];
         case (c.opcode)
            OP_ADD: v = clamp32(a + b);
            OP_SUB: v = clamp32(a - b);
            OP_MUL: v = fixed_mul(a, b);
            OP_DIV: begin
               if (b == 0) st = ST_DIVZERO;
               else v = clamp32((a <<< FRAC_BITS) / b);
            end
            OP_POW: begin
               n = b / (64'sd1 <<< FRAC_BITS);
               if (n < 0) n = 0;
               if (n > MAX_EXPONENT) n = MAX_EXPONENT;
               v = 64'sd1 <<< FRAC_BITS;
               for (int k = 0; k < n; k++) v = fixed_mul(v, a);
            end
            OP_MOD: begin
               ia = a / (64'sd1 <<< FRAC_BITS);
               ib = b / (64'sd1 <<< FRAC_BITS);
               if (ib == 0) st = ST_DIVZERO;
               else v = clamp32((ia % ib) <<< FRAC_BITS);
            end
            OP_MAX: v = (a > b) ? a : b;
            OP_MIN: v = (a < b) ? a : b;
            OP_AVG: v = (a + b) >>> 1;
            default: v = clamp32((a > b) ? (a - b) : (b - a));
         endcase
         if (st == ST_OK) begin
            calc_stack[calc_count - 2] = v[31:0];
            calc_count--;
         end
      end
      r.status = st;
      r.depth  = calc_count[2:0];
      r.top    = (calc_count == 0) ? 32'sd0 : calc_stack[calc_count - 1];
      return r;
   endfunction

   // operand values biased toward edges and small integers
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
         2: return 32'sh8000_0000 + $urandom_range(0, 3);
         3: return $signed($urandom_range(0, 20) - 10) <<< FRAC_BITS;
         4: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
         default: return $signed($urandom_range(0, 4)) - 2;
      endcase
   endfunction

   function automatic cmd_word_type make_cmd(input logic [3:0] op,
                                             input logic signed [31:0] v);
      cmd_word_type c;
      c.opcode = op;
      c.value  = v;
      return c;
   endfunction

   // stimulus: directed part, then mostly well-formed push/op sequences
   initial begin
      logic [3:0] op;
      pending_cmds.push_back(make_cmd(OP_DROP, 32'sh1234_5678));
      pending_cmds.push_back(make_cmd(OP_ADD, 0));
      pending_cmds.push_back(make_cmd(4'd13, 0));
      pending_cmds.push_back(make_cmd(4'd15, 32'shFFFF_FFFF));
      pending_cmds.push_back(make_cmd(OP_PUSH, 32'sh7FFF_FFFF));
      pending_cmds.push_back(make_cmd(OP_MUL, 0));
      pending_cmds.push_back(make_cmd(OP_PUSH, 32'sh7FFF_FFFF));
      pending_cmds.push_back(make_cmd(OP_ADD, 0));
      pending_cmds.push_back(make_cmd(OP_PUSH, 32'sh0000_0000));
      pending_cmds.push_back(make_cmd(OP_DIV, 0));
      pending_cmds.push_back(make_cmd(OP_PUSH, 32'sh0000_8000));
      pending_cmds.push_back(make_cmd(OP_MOD, 0));
      pending_cmds.push_back(make_cmd(OP_PUSH, 32'sh8000_0000));
      pending_cmds.push_back(make_cmd(OP_PUSH, 32'sh0001_8000));
      pending_cmds.push_back(make_cmd(OP_PUSH, 32'sh0050_0000));
      pending_cmds.push_back(make_cmd(OP_PUSH, 32'sh0002_0000));
      pending_cmds.push_back(make_cmd(OP_PUSH, 32'shFFFF_0000));
      pending_cmds.push_back(make_cmd(OP_POW, 0));
      pending_cmds.push_back(make_cmd(OP_POW, 0));
      pending_cmds.push_back(make_cmd(OP_SUB, 0));
      pending_cmds.push_back(make_cmd(OP_MAX, 0));
      pending_cmds.push_back(make_cmd(OP_MIN, 0));
      pending_cmds.push_back(make_cmd(OP_AVG, 0));
      pending_cmds.push_back(make_cmd(OP_ABSDIFF, 0));
      pending_cmds.push_back(make_cmd(OP_CLEAR, 0));
      for (int i = 0; i < 400; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: op = OP_PUSH;
            4: op = 4'($urandom_range(0, 15));
            5: op = (($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_DROP);
            default: op = 4'($urandom_range(OP_ADD, OP_ABSDIFF));
         endcase
         pending_cmds.push_back(make_cmd(op, pick_value()));
      end
   end

   // driver: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid         <= 1'b0;
         req_opcode        <= 4'd0;
         req_operand_value <= 32'sd0;
         burst_left        <= 0;
         gap_left          <= 0;
         calc_count        = 0;
         for (int i = 0; i < STACK_DEPTH; i++) calc_stack[i] = 32'sd0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(calc_command(make_cmd(req_opcode, req_operand_value)));
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left  <= gap_left - 1;
            end else if (pending_cmds.size() > 0) begin
               cmd_word_type c;
               c = pending_cmds.pop_front();
               req_valid         <= 1'b1;
               req_opcode        <= c.opcode;
               req_operand_value <= c.value;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
               stim_done <= 1'b1;
            end
         end
      end
   end

   // receiver stall pattern: long ready stretches, then stalls of varied length
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= (stall_phase + 1) % 97;
         if (stall_phase < 40) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 0);
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word status=%0d depth=%0d top=%h",
                     $time, rsp_status, rsp_stack_depth, rsp_top_value);
            error_count++;
         end else begin
            result_word_type e;
            e = expected_results.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               error_count++;
            end
            if (rsp_stack_depth !== e.depth) begin
               $display("%0t: depth expected %0d actual %0d", $time, e.depth,
                        rsp_stack_depth);
               error_count++;
            end
            if (rsp_top_value !== e.top) begin
               $display("%0t: top expected %h actual %h", $time, e.top, rsp_top_value);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // reset, then wait for the stream to drain
   initial begin
      error_count = 0;
      stim_done   = 1'b0;
      idle_cycles = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = 4'd0;
      req_operand_value = 32'sd0;
      rsp_ready   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (!(stim_done && expected_results.size() == 0) &&
             idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
      end else begin
         repeat (200) @(posedge clock);
         if (error_count == 0) begin
            $display("CHECK OK");
         end else begin
            $display("CHECK FAILED");
         end
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/scalc_pkg.sv
rtl/scalc_mul.sv
rtl/scalc_div.sv
rtl/stack_calculator_alu.sv
tb/sv/testbench.sv
